// File: hw/rtl/mexp_pkg.sv
package mexp_pkg;

  // width of every port field
  localparam int FIELD_W = 32;

  typedef logic [1:0] mexp_op_t;

  // operation codes for the shared modular multiplier
  localparam mexp_op_t OP_REDUCE = 2'd0;  // base mod modulus
  localparam mexp_op_t OP_SQUARE = 2'd1;  // base * base mod modulus
  localparam mexp_op_t OP_ACC    = 2'd2;  // acc * base mod modulus

  // controller to datapath
  typedef struct packed {
    logic     load;
    logic     mul_start;
    logic     commit;
    mexp_op_t op;
  } mexp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic m_zero;
    logic e_zero;
    logic e_odd;
    logic mul_done;
  } mexp_status_t;

endpackage

// File: hw/rtl/mexp_modmul.sv
module mexp_modmul import mexp_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] r
);

  localparam int CW = (W > 1) ? $clog2(W) : 1;
  localparam logic [CW-1:0] LAST = CW'(W - 1);

  logic          busy_r;
  logic          phase_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  x_r, y_r, m_r, r_r;

  logic [W:0]    dbl, dbl_red, sum, sum_red;

  // doubling step, then conditional add step; each stays below 2m
  always_comb begin
    dbl     = {r_r, 1'b0};
    dbl_red = (dbl >= {1'b0, m_r}) ? dbl - {1'b0, m_r} : dbl;
    sum     = {1'b0, r_r} + {1'b0, x_r};
    sum_red = (sum >= {1'b0, m_r}) ? sum - {1'b0, m_r} : sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        phase_r <= 1'b0;
        cnt_r   <= '0;
      end else if (busy_r) begin
        phase_r <= ~phase_r;
        if (phase_r) begin
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == LAST) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x;
      y_r <= y;
      m_r <= m;
      r_r <= '0;
    end else if (busy_r) begin
      if (!phase_r) begin
        r_r <= dbl_red[W-1:0];
      end else begin
        if (y_r[W-1]) begin
          r_r <= sum_red[W-1:0];
        end
        y_r <= {y_r[W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign r    = r_r;

endmodule

// File: hw/rtl/mexp_dp.sv
module mexp_dp import mexp_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  mexp_cmd_t    cmd,
  input  logic [W-1:0] base,
  input  logic [W-1:0] exponent,
  input  logic [W-1:0] modulus,
  output mexp_status_t status,
  output logic [W-1:0] result
);

  localparam logic [W-1:0] ONE = W'(1);

  logic [W-1:0] b_r, e_r, acc_r, m_r;
  logic         mz_r;
  mexp_op_t     op_r;

  logic [W-1:0] mx, my, mr;
  logic         mdone;

  always_comb begin
    unique case (cmd.op)
      OP_REDUCE: begin
        mx = ONE;
        my = b_r;
      end
      OP_SQUARE: begin
        mx = b_r;
        my = b_r;
      end
      OP_ACC: begin
        mx = acc_r;
        my = b_r;
      end
      default: begin
        mx = '0;
        my = '0;
      end
    endcase
  end

  mexp_modmul #(.W(W)) u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .x     (mx),
    .y     (my),
    .m     (m_r),
    .done  (mdone),
    .r     (mr)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      b_r   <= base;
      e_r   <= exponent;
      m_r   <= modulus;
      mz_r  <= (modulus == '0);
      acc_r <= ONE;
    end else begin
      if (cmd.mul_start) begin
        op_r <= cmd.op;
      end
      if (cmd.commit) begin
        unique case (op_r)
          OP_REDUCE: b_r <= mr;
          OP_SQUARE: begin
            b_r <= mr;
            e_r <= {1'b0, e_r[W-1:1]};
          end
          OP_ACC: begin
            acc_r <= mr;
            e_r   <= {e_r[W-1:1], 1'b0};
          end
          default: ;
        endcase
      end
    end
  end

  assign status.m_zero   = mz_r;
  assign status.e_zero   = (e_r == '0);
  assign status.e_odd    = e_r[0];
  assign status.mul_done = mdone;
  assign result          = mz_r ? '0 : acc_r;

endmodule

// File: hw/rtl/mexp_ctrl.sv
module mexp_ctrl import mexp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  mexp_status_t status,
  output mexp_cmd_t    cmd,
  output logic         busy,
  output logic         done
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MODCK = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd.load      = 1'b0;
    cmd.mul_start = 1'b0;
    cmd.commit    = 1'b0;
    cmd.op        = OP_REDUCE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_MODCK;
        end
      end
      S_MODCK: begin
        if (status.m_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.op        = OP_REDUCE;
          state_nxt     = S_MUL;
        end
      end
      S_MUL: begin
        if (status.mul_done) begin
          cmd.commit = 1'b1;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.e_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.op        = status.e_odd ? OP_ACC : OP_SQUARE;
          state_nxt     = S_MUL;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);

endmodule

// File: hw/rtl/modular_exponentiation.sv
// modular exponentiation: out_result = in_base ^ in_exponent mod in_modulus, using
// right-to-left binary exponentiation. a request is taken when start is high and
// busy is low; the answer appears on out_result for exactly one cycle with
// out_valid high and is not held, so the receiver must take it then. only the low
// OPERAND_WIDTH bits of each field are used. an exponent of zero gives 1 for any
// modulus, including 1; a modulus of zero gives 0. one request is in flight at a
// time. all work runs through one shared bit-serial modular multiplier that spends
// a doubling phase and an add phase on each operand bit. a request takes 1
// reduction step plus one step per set exponent bit plus one per bit position
// below the top set bit, i.e. at most 2*OPERAND_WIDTH steps.
module modular_exponentiation import mexp_pkg::*; #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [FIELD_W-1:0] in_base,
  input  logic [FIELD_W-1:0] in_exponent,
  input  logic [FIELD_W-1:0] in_modulus,
  output logic               out_valid,
  output logic [FIELD_W-1:0] out_result
);

  localparam int W = OPERAND_WIDTH;

  // command and status between the sequencer and the datapath
  mexp_cmd_t    cmd;
  mexp_status_t status;
  logic [W-1:0] result;

  // sequencer: load, then unless the modulus is zero reduce base and square or multiply until exponent is zero
  mexp_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (out_valid)
  );

  // datapath: operand registers plus the shared modular multiplier
  mexp_dp #(.W(W)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .base     (in_base[W-1:0]),
    .exponent (in_exponent[W-1:0]),
    .modulus  (in_modulus[W-1:0]),
    .status   (status),
    .result   (result)
  );

  // widen the result to the port width
  assign out_result = FIELD_W'(result);

  // the strobe lasts one cycle only
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // an accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // a multiplier completion only happens while a request is in progress
  a_mul_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    status.mul_done |-> (busy && !out_valid))
    else $error("multiplier finished outside a request");

  // a result is never issued while a multiply is starting
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_start |=> !out_valid)
    else $error("result issued during a multiply");

endmodule
